@@ rtl/acsc_pkg.sv @@
// Shared types, constants and result codes for the clip-space box cull pipeline.
`timescale 1ns / 1ps
package acsc_pkg;

  localparam int Q_W         = 32;
  localparam int THR_W       = 18;
  localparam int NCORNER     = 8;
  localparam int IN_DATA_W   = 216;
  localparam int OUT_DATA_W  = 8;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 64;

  // Pipeline geometry.
  localparam int XF_LAT      = 3;
  localparam int DIV_BITS    = 2;
  localparam int DIV_QBITS   = 32;
  localparam int DIV_STAGES  = DIV_QBITS / DIV_BITS;
  localparam int DIV_LAT     = DIV_STAGES + 2;
  localparam int DEC_LAT     = 4;
  localparam int SIDE_LAT    = XF_LAT + DIV_LAT;
  localparam int PIPE_LAT    = XF_LAT + DIV_LAT + DEC_LAT;

  localparam logic signed [32:0] NEAR_EPS_RAW = 33'sd6;

  typedef enum logic [2:0] {
    RSN_INSIDE  = 3'd0,
    RSN_INVALID = 3'd1,
    RSN_NEAR    = 3'd2,
    RSN_OUTSIDE = 3'd3,
    RSN_SMALL   = 3'd4
  } reason_t;

  typedef logic [3:0][3:0][Q_W-1:0]      mat_t;
  typedef logic [2:0][Q_W-1:0]           vec3_t;
  typedef logic [NCORNER-1:0][3:0][Q_W-1:0] clip_t;
  typedef logic [NCORNER-1:0][Q_W-1:0]   ndc8_t;

  // Default matrix, rows 3 down to 0, each row from column 3 down to 0.
  localparam mat_t MAT_RESET = {
    {32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
    {32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000},
    {32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000},
    {32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000}
  };

  typedef struct packed {
    logic crosses;
    logic outside;
  } flags_t;

  typedef struct packed {
    logic             box_valid;
    logic [THR_W-1:0] thr;
  } side_t;

endpackage

@@ rtl/acsc_xform.sv @@
// Three-stage corner transform: products, floor and saturate, sum and saturate.
`timescale 1ns / 1ps
module acsc_xform (
  input  logic           clk,
  input  logic           en,
  input  acsc_pkg::vec3_t box_min,
  input  acsc_pkg::vec3_t box_max,
  input  acsc_pkg::mat_t  mat,
  output acsc_pkg::clip_t clip
);
  import acsc_pkg::*;

  localparam logic signed [47:0] SAT_HI = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] SAT_LO = -48'sh0000_8000_0000;

  function automatic logic [31:0] sat48(input logic signed [47:0] v);
    logic [31:0] res;
    if (v > SAT_HI) begin
      res = 32'h7FFF_FFFF;
    end else if (v < SAT_LO) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // Products only depend on the axis, the min/max choice and the column,
  // so 24 multipliers cover all eight corners.
  logic signed [63:0] prod_r [3][2][4];
  logic        [31:0] term_r [3][2][4];
  clip_t              clip_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int j = 0; j < 4; j++) begin
          prod_r[a][0][j] <= $signed(box_min[a]) * $signed(mat[a][j]);
          prod_r[a][1][j] <= $signed(box_max[a]) * $signed(mat[a][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int s = 0; s < 2; s++) begin
          for (int j = 0; j < 4; j++) begin
            term_r[a][s][j] <= sat48($signed(prod_r[a][s][j][63:16]));
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [33:0] sum;
    if (en) begin
      for (int c = 0; c < NCORNER; c++) begin
        for (int j = 0; j < 4; j++) begin
          sum = $signed({{2{term_r[0][c[0]][j][31]}}, term_r[0][c[0]][j]})
              + $signed({{2{term_r[1][c[1]][j][31]}}, term_r[1][c[1]][j]})
              + $signed({{2{term_r[2][c[2]][j][31]}}, term_r[2][c[2]][j]})
              + $signed({{2{mat[3][j][31]}}, mat[3][j]});
          clip_r[c][j] <= sat48($signed({{14{sum[33]}}, sum}));
        end
      end
    end
  end

  assign clip = clip_r;

endmodule

@@ rtl/acsc_ndc_div.sv @@
// Pipelined restoring divider for (c << 16) / w, truncated and saturated to 32 bits.
`timescale 1ns / 1ps
module acsc_ndc_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo
);
  import acsc_pkg::*;

  logic [31:0] rem_r  [DIV_STAGES+1];
  logic [31:0] dvd_r  [DIV_STAGES+1];
  logic [31:0] q_r    [DIV_STAGES+1];
  logic [31:0] d_r    [DIV_STAGES+1];
  logic        neg_r  [DIV_STAGES+1];
  logic        ovf_r  [DIV_STAGES+1];
  logic [31:0] rem_nxt [DIV_STAGES];
  logic [31:0] dvd_nxt [DIV_STAGES];
  logic [31:0] q_nxt   [DIV_STAGES];
  logic [31:0] quo_r;
  logic [31:0] mag;

  assign mag = num[31] ? (~num + 32'd1) : num;

  // Setup: magnitude, divisor and the overflow check |c| >= w * 2^15.
  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= num[31];
      ovf_r[0] <= ({14'd0, mag} >= {den[30:0], 15'd0});
      d_r[0]   <= {1'b0, den[30:0]};
      rem_r[0] <= {16'd0, mag[31:16]};
      dvd_r[0] <= {mag[15:0], 16'd0};
      q_r[0]   <= '0;
    end
  end

  always_comb begin
    logic [32:0] rs;
    logic [31:0] r;
    logic [31:0] n;
    logic [31:0] q;
    for (int s = 0; s < DIV_STAGES; s++) begin
      r = rem_r[s];
      n = dvd_r[s];
      q = q_r[s];
      for (int b = 0; b < DIV_BITS; b++) begin
        rs = {r, n[31]};
        n  = {n[30:0], 1'b0};
        if (rs >= {1'b0, d_r[s]}) begin
          rs = rs - {1'b0, d_r[s]};
          q  = {q[30:0], 1'b1};
        end else begin
          q  = {q[30:0], 1'b0};
        end
        r = rs[31:0];
      end
      rem_nxt[s] = r;
      dvd_nxt[s] = n;
      q_nxt[s]   = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_r[s+1] <= rem_nxt[s];
        dvd_r[s+1] <= dvd_nxt[s];
        q_r[s+1]   <= q_nxt[s];
        d_r[s+1]   <= d_r[s];
        neg_r[s+1] <= neg_r[s];
        ovf_r[s+1] <= ovf_r[s];
      end
    end
  end

  // Without overflow the quotient is below 2^31, so negation cannot wrap.
  always_ff @(posedge clk) begin
    if (en) begin
      if (ovf_r[DIV_STAGES]) begin
        quo_r <= neg_r[DIV_STAGES] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        quo_r <= neg_r[DIV_STAGES] ? (~q_r[DIV_STAGES] + 32'd1) : q_r[DIV_STAGES];
      end
    end
  end

  assign quo = quo_r;

endmodule

@@ rtl/acsc_decide.sv @@
// Registered min/max tree over the NDC corners and the final cull decision.
`timescale 1ns / 1ps
module acsc_decide (
  input  logic             clk,
  input  logic             en,
  input  acsc_pkg::ndc8_t  ndc_x,
  input  acsc_pkg::ndc8_t  ndc_y,
  input  acsc_pkg::flags_t flags,
  input  acsc_pkg::side_t  side,
  output logic             visible,
  output acsc_pkg::reason_t reason
);
  import acsc_pkg::*;

  logic [31:0] mnx1_r [4], mxx1_r [4], mny1_r [4], mxy1_r [4];
  logic [31:0] mnx2_r [2], mxx2_r [2], mny2_r [2], mxy2_r [2];
  logic [31:0] mnx3_r, mxx3_r, mny3_r, mxy3_r;
  flags_t      flags_r [3];
  side_t       side_r  [3];
  logic        visible_r;
  reason_t     reason_r;

  function automatic logic [31:0] smin(input logic [31:0] a, input logic [31:0] b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  function automatic logic [31:0] smax(input logic [31:0] a, input logic [31:0] b);
    return ($signed(a) > $signed(b)) ? a : b;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        mnx1_r[k] <= smin(ndc_x[2*k], ndc_x[2*k+1]);
        mxx1_r[k] <= smax(ndc_x[2*k], ndc_x[2*k+1]);
        mny1_r[k] <= smin(ndc_y[2*k], ndc_y[2*k+1]);
        mxy1_r[k] <= smax(ndc_y[2*k], ndc_y[2*k+1]);
      end
      for (int k = 0; k < 2; k++) begin
        mnx2_r[k] <= smin(mnx1_r[2*k], mnx1_r[2*k+1]);
        mxx2_r[k] <= smax(mxx1_r[2*k], mxx1_r[2*k+1]);
        mny2_r[k] <= smin(mny1_r[2*k], mny1_r[2*k+1]);
        mxy2_r[k] <= smax(mxy1_r[2*k], mxy1_r[2*k+1]);
      end
      mnx3_r <= smin(mnx2_r[0], mnx2_r[1]);
      mxx3_r <= smax(mxx2_r[0], mxx2_r[1]);
      mny3_r <= smin(mny2_r[0], mny2_r[1]);
      mxy3_r <= smax(mxy2_r[0], mxy2_r[1]);
      flags_r[0] <= flags;
      side_r[0]  <= side;
      for (int k = 1; k < 3; k++) begin
        flags_r[k] <= flags_r[k-1];
        side_r[k]  <= side_r[k-1];
      end
    end
  end

  // With no corner crossing near, every corner fed the tree, so the
  // extents are never negative here.
  always_ff @(posedge clk) begin
    logic signed [32:0] ext_x;
    logic signed [32:0] ext_y;
    logic signed [32:0] thr_s;
    if (en) begin
      ext_x = $signed({mxx3_r[31], mxx3_r}) - $signed({mnx3_r[31], mnx3_r});
      ext_y = $signed({mxy3_r[31], mxy3_r}) - $signed({mny3_r[31], mny3_r});
      thr_s = $signed({15'd0, side_r[2].thr});
      if (!side_r[2].box_valid) begin
        visible_r <= 1'b1;
        reason_r  <= RSN_INVALID;
      end else if (flags_r[2].crosses) begin
        visible_r <= 1'b1;
        reason_r  <= RSN_NEAR;
      end else if (flags_r[2].outside) begin
        visible_r <= 1'b0;
        reason_r  <= RSN_OUTSIDE;
      end else if ((side_r[2].thr != '0) && (ext_x < thr_s) && (ext_y < thr_s)) begin
        visible_r <= 1'b0;
        reason_r  <= RSN_SMALL;
      end else begin
        visible_r <= 1'b1;
        reason_r  <= RSN_INSIDE;
      end
    end
  end

  assign visible = visible_r;
  assign reason  = reason_r;

endmodule

@@ rtl/aabb_clip_space_cull.sv @@
// Top level of the clip-space box cull: ports, matrix registers, plane flags, stall control.
//
//   Channel   Direction  Transfer fields
//   in_       slave      tdata: box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
//                        box_max_z, min_ndc_extent; tuser: box_valid
//   out_      master     tdata: visible; tuser: cull_reason
//   cfg_      write      cfg_addr selects one of eight 64-bit matrix registers
//
// One box is accepted every cycle while the output is not stalled. Each result passes through
// the 3-stage corner transform, then the pipelined NDC dividers (a setup register, stages of
// two quotient bits each, an output register), then the 4-stage min/max and decision stages.
// Synchronous reset empties the pipeline and loads the default matrix; no clearing pass.
// A stall at the output freezes every stage at once, so nothing is lost or repeated.
`timescale 1ns / 1ps
module aabb_clip_space_cull (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, min_ndc_extent
  input  logic [acsc_pkg::IN_DATA_W-1:0]       in_tdata,
  // box_valid
  input  logic [0:0]                           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // visible
  output logic [acsc_pkg::OUT_DATA_W-1:0]      out_tdata,
  // cull_reason
  output logic [2:0]                           out_tuser,
  input  logic                                 cfg_wr_en,
  input  logic [acsc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [acsc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import acsc_pkg::*;

  logic              en;
  logic [PIPE_LAT-1:0] vld_r;
  mat_t              m_r;
  vec3_t             box_min;
  vec3_t             box_max;
  clip_t             clip;
  side_t             side_r  [SIDE_LAT];
  flags_t            flags_r [DIV_LAT];
  flags_t            flags_nxt;
  ndc8_t             ndc_x;
  ndc8_t             ndc_y;
  logic              visible;
  reason_t           reason;

  assign en        = !vld_r[PIPE_LAT-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_tvalid};
    end
  end

  // Matrix registers: low half is the even column, high half the odd one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= MAT_RESET;
    end else if (cfg_wr_en) begin
      m_r[cfg_addr[2:1]][{cfg_addr[0], 1'b0}] <= cfg_wdata[31:0];
      m_r[cfg_addr[2:1]][{cfg_addr[0], 1'b1}] <= cfg_wdata[63:32];
    end
  end

  assign box_min = {in_tdata[95:64], in_tdata[63:32], in_tdata[31:0]};
  assign box_max = {in_tdata[191:160], in_tdata[159:128], in_tdata[127:96]};

  acsc_xform u_xform (
    .clk     (clk),
    .en      (en),
    .box_min (box_min),
    .box_max (box_max),
    .mat     (m_r),
    .clip    (clip)
  );

  // Side data rides beside the transform and the dividers.
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= {in_tuser[0], in_tdata[209:192]};
      for (int k = 1; k < SIDE_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // A box is outside when all corners fail the same plane; compares use 33 bits.
  always_comb begin
    logic signed [32:0] x, y, z, w;
    logic [5:0] all_out;
    flags_nxt.crosses = 1'b0;
    all_out = '1;
    for (int c = 0; c < NCORNER; c++) begin
      x = $signed({clip[c][0][31], clip[c][0]});
      y = $signed({clip[c][1][31], clip[c][1]});
      z = $signed({clip[c][2][31], clip[c][2]});
      w = $signed({clip[c][3][31], clip[c][3]});
      if (w <= NEAR_EPS_RAW) flags_nxt.crosses = 1'b1;
      if (!(x < -w))      all_out[0] = 1'b0;
      if (!(x > w))       all_out[1] = 1'b0;
      if (!(y < -w))      all_out[2] = 1'b0;
      if (!(y > w))       all_out[3] = 1'b0;
      if (!(z < 33'sd0))  all_out[4] = 1'b0;
      if (!(z > w))       all_out[5] = 1'b0;
    end
    flags_nxt.outside = |all_out;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags_r[0] <= flags_nxt;
      for (int k = 1; k < DIV_LAT; k++) begin
        flags_r[k] <= flags_r[k-1];
      end
    end
  end

  for (genvar c = 0; c < NCORNER; c++) begin : g_div
    acsc_ndc_div u_div_x (
      .clk (clk),
      .en  (en),
      .num (clip[c][0]),
      .den (clip[c][3]),
      .quo (ndc_x[c])
    );
    acsc_ndc_div u_div_y (
      .clk (clk),
      .en  (en),
      .num (clip[c][1]),
      .den (clip[c][3]),
      .quo (ndc_y[c])
    );
  end

  acsc_decide u_decide (
    .clk     (clk),
    .en      (en),
    .ndc_x   (ndc_x),
    .ndc_y   (ndc_y),
    .flags   (flags_r[DIV_LAT-1]),
    .side    (side_r[SIDE_LAT-1]),
    .visible (visible),
    .reason  (reason)
  );

  assign out_tvalid = vld_r[PIPE_LAT-1];
  assign out_tdata  = {{(OUT_DATA_W-1){1'b0}}, visible};
  assign out_tuser  = reason;

  a_vis_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == ((out_tuser == RSN_INSIDE) ||
                                     (out_tuser == RSN_INVALID) ||
                                     (out_tuser == RSN_NEAR))))
    else $error("visible bit disagrees with cull reason");

  a_reason_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == RSN_INSIDE) || (out_tuser == RSN_INVALID) ||
                    (out_tuser == RSN_NEAR) || (out_tuser == RSN_OUTSIDE) ||
                    (out_tuser == RSN_SMALL)))
    else $error("cull reason outside the defined codes");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while the output stage is stalled");

endmodule
